@@ rtl/core/mid_pkg.sv @@
`timescale 1ns / 1ps

package mid_pkg;

  // Fixed widths of the sample and event fields.
  localparam int SampleBits     = 16;
  localparam int WindowWidth    = 8;
  localparam int BoardWidth     = 3;
  localparam int PortWidth      = 5;
  localparam int CfgDataWidth   = 8;
  localparam int CfgIndexWidth  = 2;

  // Default port count and the cap on events reported for one sample.
  localparam int NumPortsDefault = 16;
  localparam int MaxEvents       = 16;

  // Reset values of the configuration registers.
  localparam logic [WindowWidth-1:0] WindowReset = 8'd4;
  localparam logic [BoardWidth-1:0]  BoardReset  = 3'd0;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;

  // Configuration register indexes.
  localparam cfg_index_t CFG_WINDOW   = 2'd0;
  localparam cfg_index_t CFG_BOARD_ID = 2'd1;

endpackage

@@ rtl/core/mid_front.sv @@
`timescale 1ns / 1ps

module mid_front #(
  parameter int NUM_PORTS = mid_pkg::NumPortsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [mid_pkg::SampleBits-1:0]   raw_pins,
  input  logic [mid_pkg::WindowWidth-1:0]  window,
  output logic                             push,
  output logic [NUM_PORTS-1:0]             change_mask,
  output logic [NUM_PORTS-1:0]             level_vec
);

  logic [mid_pkg::WindowWidth-1:0] counters [NUM_PORTS];
  logic [NUM_PORTS-1:0]            levels;

  logic [mid_pkg::WindowWidth-1:0] counters_next [NUM_PORTS];
  logic [NUM_PORTS-1:0]            levels_next;

  for (genvar p = 0; p < NUM_PORTS; p++) begin : g_lane
    logic                          high;
    logic [mid_pkg::WindowWidth:0] stepped;

    // Ports past the sampled width idle high like an open pull-up.
    if (p < mid_pkg::SampleBits) begin : g_sampled
      assign high = raw_pins[p];
    end else begin : g_idle
      assign high = 1'b1;
    end

    always_comb begin
      if (high) begin
        stepped = (counters[p] == '0) ? '0 : {1'b0, counters[p]} - 1'b1;
      end else begin
        stepped = {1'b0, counters[p]} + 1'b1;
      end
      if (stepped > {1'b0, window}) begin
        counters_next[p] = window;
      end else begin
        counters_next[p] = stepped[mid_pkg::WindowWidth-1:0];
      end

      levels_next[p] = levels[p];
      if (!levels[p] && counters_next[p] == window) begin
        levels_next[p] = 1'b1;
      end else if (levels[p] && counters_next[p] == '0) begin
        levels_next[p] = 1'b0;
      end
    end

    assign change_mask[p] = levels_next[p] ^ levels[p];
  end

  assign level_vec = levels_next;
  assign push      = accept && (|change_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        counters[i] <= '0;
      end
      levels <= '0;
    end else if (accept) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        counters[i] <= counters_next[i];
      end
      levels <= levels_next;
    end
  end

endmodule

@@ rtl/core/mid_fifo.sv @@
`timescale 1ns / 1ps

module mid_fifo #(
  parameter int WIDTH = 2 * mid_pkg::NumPortsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  // Two entries: enough for the front to run a sample ahead of the back.
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign not_full  = (fill != 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/mid_back.sv @@
`timescale 1ns / 1ps

module mid_back #(
  parameter int NUM_PORTS = mid_pkg::NumPortsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             entry_valid,
  input  logic [NUM_PORTS-1:0]             entry_mask,
  input  logic [NUM_PORTS-1:0]             entry_levels,
  output logic                             entry_pop,
  input  logic [mid_pkg::BoardWidth-1:0]   board_id,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mid_pkg::BoardWidth-1:0]   board,
  output logic [mid_pkg::PortWidth-1:0]    port,
  output logic                             level,
  output logic                             last
);

  localparam int IdxWidth   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CountWidth = $clog2(mid_pkg::MaxEvents);

  logic                  busy;
  logic [NUM_PORTS-1:0]  mask;
  logic [NUM_PORTS-1:0]  levels;
  logic [CountWidth-1:0] emitted;

  logic [IdxWidth-1:0]   idx;
  logic [NUM_PORTS-1:0]  mask_next;
  logic [6:0]            port_num;
  logic                  step;
  logic                  is_last;
  logic                  load;

  // Lowest pending port goes first.
  always_comb begin
    idx = '0;
    for (int i = NUM_PORTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IdxWidth'(i);
      end
    end
  end

  always_comb begin
    mask_next      = mask;
    mask_next[idx] = 1'b0;
  end

  assign port_num  = 7'(idx) + 7'd1;
  assign step      = busy && (!out_valid || out_ready);
  assign is_last   = (mask_next == '0) ||
                     (emitted == CountWidth'(mid_pkg::MaxEvents - 1));
  assign load      = entry_valid && (!busy || (step && is_last));
  assign entry_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (step && is_last) begin
        busy <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mask    <= entry_mask;
      levels  <= entry_levels;
      emitted <= '0;
    end else if (step) begin
      mask    <= mask_next;
      emitted <= emitted + 1'b1;
    end
    if (step) begin
      board <= board_id;
      port  <= port_num[mid_pkg::PortWidth-1:0];
      level <= levels[idx];
      last  <= is_last;
    end
  end

endmodule

@@ rtl/core/multi_input_integrator_debounce.sv @@
`timescale 1ns / 1ps
// Change events pass from the queue through the scanner's mask register to the output register.
// Throughput: a sample word is accepted every cycle while the two-entry change queue has room;
// the event scanner delivers one event word per cycle while it holds a change set and the output is ready.
// Reset (rst, synchronous, active high) clears all counters and levels, empties the queue and
// the output, and sets window to 4 and board_id to 0.

module multi_input_integrator_debounce #(
  parameter int NUM_PORTS = mid_pkg::NumPortsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_wr_en,
  input  mid_pkg::cfg_index_t               cfg_index,
  input  logic [mid_pkg::CfgDataWidth-1:0]  cfg_data,
  // Sample input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mid_pkg::SampleBits-1:0]    raw_pins,
  // Change event output channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mid_pkg::BoardWidth-1:0]    board,
  output logic [mid_pkg::PortWidth-1:0]     port,
  output logic                              level,
  output logic                              last
);

  logic [mid_pkg::WindowWidth-1:0] window;
  logic [mid_pkg::BoardWidth-1:0]  board_id;

  logic                            accept;
  logic                            push;
  logic [NUM_PORTS-1:0]            change_mask;
  logic [NUM_PORTS-1:0]            level_vec;
  logic                            q_not_full;
  logic                            q_not_empty;
  logic                            q_pop;
  logic [2*NUM_PORTS-1:0]          q_data;

  // Configuration registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= mid_pkg::WindowReset;
      board_id <= mid_pkg::BoardReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mid_pkg::CFG_WINDOW: begin
          window <= cfg_data[mid_pkg::WindowWidth-1:0];
        end
        mid_pkg::CFG_BOARD_ID: begin
          board_id <= cfg_data[mid_pkg::BoardWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The front end updates every integrator the cycle a word is accepted, so it only
  // waits when the queue toward the scanner is full.
  assign in_ready = q_not_full;
  assign accept   = in_valid && in_ready;

  mid_front #(
    .NUM_PORTS(NUM_PORTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .raw_pins   (raw_pins),
    .window     (window),
    .push       (push),
    .change_mask(change_mask),
    .level_vec  (level_vec)
  );

  // Each queue entry holds the set of ports that changed and their new levels.
  // Quiet samples never enter the queue.
  mid_fifo #(
    .WIDTH(2 * NUM_PORTS)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({change_mask, level_vec}),
    .not_full (q_not_full),
    .pop      (q_pop),
    .pop_data (q_data),
    .not_empty(q_not_empty)
  );

  // The back end walks the change set in ascending port order into the output register.
  mid_back #(
    .NUM_PORTS(NUM_PORTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (q_not_empty),
    .entry_mask  (q_data[2*NUM_PORTS-1:NUM_PORTS]),
    .entry_levels(q_data[NUM_PORTS-1:0]),
    .entry_pop   (q_pop),
    .board_id    (board_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .board       (board),
    .port        (port),
    .level       (level),
    .last        (last)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // Register indexes past the end of the register list. Writes to them must be dropped.
  localparam mid_pkg::cfg_index_t CFG_SPARE_A = 2'd2;
  localparam mid_pkg::cfg_index_t CFG_SPARE_B = 2'd3;

  // Cycles allowed after the last event word before the block is treated as idle. A sample
  // that changes nothing produces no word, so this covers the pipeline and the change queue.
  localparam int SettleCycles = 40;
  // Hard stop for the whole run, well above the slowest legal run with every stall phase.
  localparam int CycleLimit   = 500000;
  // Length of the long output hold-off used to fill the block up.
  localparam int HoldOffCycles = 300;

  // One change event word as it leaves the block.
  typedef struct packed {
    logic [mid_pkg::BoardWidth-1:0] board;
    logic [mid_pkg::PortWidth-1:0]  port;
    logic                           level;
    logic                           last;
  } change_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_wr_en = 1'b0;
  mid_pkg::cfg_index_t              cfg_index = mid_pkg::CFG_WINDOW;
  logic [mid_pkg::CfgDataWidth-1:0] cfg_data  = '0;

  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  logic [mid_pkg::SampleBits-1:0]   raw_pins  = '1;

  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [mid_pkg::BoardWidth-1:0]   board;
  logic [mid_pkg::PortWidth-1:0]    port;
  logic                             level;
  logic                             last;

  // Debounce state as the block should hold it, plus its copy of the two registers.
  logic [mid_pkg::WindowWidth-1:0]  window_reg = mid_pkg::WindowReset;
  logic [mid_pkg::BoardWidth-1:0]   board_reg  = mid_pkg::BoardReset;
  int unsigned                      pin_count [mid_pkg::SampleBits] = '{default: 0};
  logic                             pin_level [mid_pkg::SampleBits] = '{default: 1'b0};

  // Change events predicted but not yet seen on the output, oldest first.
  change_event_t awaited_events[$];

  int mismatches     = 0;
  int cycle          = 0;
  int hold_until     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  multi_input_integrator_debounce DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .raw_pins  (raw_pins),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .board     (board),
    .port      (port),
    .level     (level),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter and the overall timeout. The counter is updated with a nonblocking
  // assignment so every process that reads it at an edge sees the same value.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side. The receiver stalls at random at the rate of the current phase, and holds
  // off completely while a requested hold-off window is open.
  always @(posedge clk) begin
    out_ready <= !rst && (cycle >= hold_until) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Integrates one accepted sample into the predicted state and queues the change events it
  // causes, in ascending port order, with the last one of the sample flagged.
  task automatic integrate_sample(input logic [mid_pkg::SampleBits-1:0] pins);
    change_event_t batch[$];
    change_event_t ev;
    int unsigned   next_count;
    logic          changed;
    for (int p = 0; p < mid_pkg::SampleBits; p++) begin
      // A high pin counts down toward zero, a low pin counts up; then clamp to the window.
      // The clamp comes after the count step, which matters when the window was lowered.
      if (pins[p]) begin
        next_count = (pin_count[p] == 0) ? 0 : pin_count[p] - 1;
      end else begin
        next_count = pin_count[p] + 1;
      end
      if (next_count > window_reg) begin
        next_count = window_reg;
      end
      pin_count[p] = next_count;
      // With a window of zero both rules hold at once, so the level toggles every sample.
      changed = 1'b0;
      if (!pin_level[p] && next_count == window_reg) begin
        pin_level[p] = 1'b1;
        changed = 1'b1;
      end else if (pin_level[p] && next_count == 0) begin
        pin_level[p] = 1'b0;
        changed = 1'b1;
      end
      if (changed) begin
        ev.board = board_reg;
        ev.port  = mid_pkg::PortWidth'(p + 1);
        ev.level = pin_level[p];
        ev.last  = 1'b0;
        batch.push_back(ev);
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) begin
      awaited_events.push_back(batch[i]);
    end
  endtask

  // Offers one sample word, after a random gap at the current idle rate, and waits until it is
  // accepted. Valid stays high on return so that the next word can follow without a bubble.
  task automatic offer_sample(input logic [mid_pkg::SampleBits-1:0] pins);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_pins <= pins;
    do @(posedge clk); while (!in_ready);
    integrate_sample(pins);
  endtask

  // Stops offering words, waits for every predicted event, then lets the block settle so that
  // samples without events have left the pipeline as well.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes one register and mirrors the write in the predicted configuration. Only called
  // while the block is idle.
  task automatic program_reg(input mid_pkg::cfg_index_t idx,
                             input logic [mid_pkg::CfgDataWidth-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      mid_pkg::CFG_WINDOW:   window_reg = data;
      mid_pkg::CFG_BOARD_ID: board_reg  = data[mid_pkg::BoardWidth-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Reset values: window 4 and board 0. Four low samples set every port, four high samples
  // clear them again, and the samples in between are quiet.
  task automatic test_reset_defaults();
    set_idling(0, 0);
    repeat (4) offer_sample(16'h0000);
    repeat (4) offer_sample(16'hFFFF);
  endtask

  // Window of one, so each sample moves levels directly. The lowest and the highest port are
  // checked alone and in one sample, then alternating patterns flip half the ports, then all.
  task automatic test_single_ports();
    drain_events();
    program_reg(mid_pkg::CFG_WINDOW, 8'd1);
    // Upper data bits are beyond the register and must be dropped, leaving board 7.
    program_reg(mid_pkg::CFG_BOARD_ID, 8'hFF);
    offer_sample(16'hFFFE);
    offer_sample(16'h7FFF);
    offer_sample(16'hFFFF);
    offer_sample(16'hAAAA);
    offer_sample(16'h5555);
  endtask

  // Counters parked at 3 under a window of 6; the window is then lowered to 2. On the next
  // sample a low pin counts to 4 and clamps to the new window, a high pin counts down to 2,
  // and both set the level.
  task automatic test_window_lowered();
    drain_events();
    program_reg(mid_pkg::CFG_WINDOW, 8'd6);
    program_reg(mid_pkg::CFG_BOARD_ID, 8'd0);
    offer_sample(16'hFFFF);
    repeat (3) offer_sample(16'h0000);
    drain_events();
    program_reg(mid_pkg::CFG_WINDOW, 8'd2);
    offer_sample(16'hFF00);
    repeat (2) offer_sample(16'hFFFF);
  endtask

  // A window of zero pins every counter at zero, so every level toggles on every sample,
  // whatever the pins read.
  task automatic test_window_zero();
    drain_events();
    program_reg(mid_pkg::CFG_WINDOW, 8'd0);
    repeat (3) offer_sample(mid_pkg::SampleBits'($urandom));
  endtask

  // Writes to indexes past the register list must leave window and board untouched.
  task automatic test_unknown_index();
    drain_events();
    program_reg(mid_pkg::CFG_WINDOW, 8'd1);
    program_reg(mid_pkg::CFG_BOARD_ID, 8'd5);
    program_reg(CFG_SPARE_A, 8'hA5);
    program_reg(CFG_SPARE_B, 8'h5A);
    offer_sample(16'h0000);
    offer_sample(16'hFFFF);
  endtask

  // Wide window: counters must saturate at the window while low samples keep coming. Then
  // the window drops to one and the saturated counters clamp down on the next sample.
  task automatic test_window_extremes();
    drain_events();
    set_idling(0, 0);
    program_reg(mid_pkg::CFG_WINDOW, 8'd12);
    program_reg(mid_pkg::CFG_BOARD_ID, 8'd3);
    repeat (14) offer_sample(16'h0000);
    drain_events();
    program_reg(mid_pkg::CFG_WINDOW, 8'd1);
    repeat (2) offer_sample(16'hFFFF);
  endtask

  // Every sample flips all sixteen levels while the output is held off, so the change queue
  // fills and the input must stall. Afterwards the sender waits for every event to arrive.
  task automatic test_backpressure();
    drain_events();
    set_idling(0, 0);
    program_reg(mid_pkg::CFG_WINDOW, 8'd1);
    hold_until = cycle + HoldOffCycles;
    for (int i = 0; i < 12; i++) begin
      offer_sample((i % 2 == 0) ? 16'h0000 : 16'hFFFF);
    end
    drain_events();
  endtask

  // Random traffic for one idling phase. Most of it is runs of one random pattern held long
  // enough to cross the window, with an occasional bounced bit; the rest is plain noise.
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    logic [mid_pkg::SampleBits-1:0] base;
    logic [mid_pkg::SampleBits-1:0] pins;
    int                             w;
    int                             run;
    int                             flip;
    int                             sent;
    drain_events();
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    program_reg(mid_pkg::CFG_WINDOW, mid_pkg::CfgDataWidth'(w));
    program_reg(mid_pkg::CFG_BOARD_ID, mid_pkg::CfgDataWidth'($urandom_range(0, 255)));
    set_idling(send_pct, recv_pct);
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        base = mid_pkg::SampleBits'($urandom);
        run  = $urandom_range(1, 2 * w + 2);
        if (run > count - sent) begin
          run = count - sent;
        end
        repeat (run) begin
          pins = base;
          if ($urandom_range(0, 7) == 0) begin
            flip = $urandom_range(0, mid_pkg::SampleBits - 1);
            pins[flip] = ~pins[flip];
          end
          offer_sample(pins);
          sent++;
        end
      end else begin
        offer_sample(mid_pkg::SampleBits'($urandom));
        sent++;
      end
    end
  endtask

  // Every accepted event word is compared with the oldest prediction, field by field.
  always @(posedge clk) begin : check_events
    change_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_events.size() == 0) begin
        $error("event word with nothing awaited: board %0d port %0d level %0d last %0d",
               board, port, level, last);
        mismatches++;
      end else begin
        want = awaited_events.pop_front();
        if (board !== want.board) begin
          $error("board: expected %0d, got %0d", want.board, board);
          mismatches++;
        end
        if (port !== want.port) begin
          $error("port: expected %0d, got %0d", want.port, port);
          mismatches++;
        end
        if (level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, level);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_single_ports();
    test_window_lowered();
    test_window_zero();
    test_unknown_index();
    test_window_extremes();
    test_backpressure();

    // Idling phases: none, a mostly idle sender, a mostly stalled receiver, then light
    // idling on both sides.
    test_random_traffic(0, 0, 29);
    test_random_traffic(85, 0, 29);
    test_random_traffic(0, 85, 29);
    test_random_traffic(8, 8, 29);

    drain_events();
    if (mismatches == 0 && awaited_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ multi_input_integrator_debounce.f @@
rtl/core/mid_pkg.sv
rtl/core/mid_front.sv
rtl/core/mid_fifo.sv
rtl/core/mid_back.sv
rtl/core/multi_input_integrator_debounce.sv
tb/testbench.sv
